/* src/etcb_pkg.sv */
// ----------------------------------------------------------------------------
// etcb_pkg
// Shared constants, coefficient tables and types for the camera basis unit.
// ----------------------------------------------------------------------------
package etcb_pkg;

  // angle and vector formats
  localparam int ANGLE_W          = 15;
  localparam int ANGLE_FRAC_BITS  = 6;
  localparam int VECTOR_FRAC_BITS = 14;
  localparam int OUT_W            = VECTOR_FRAC_BITS + 2;

  // angle reduction limits, in input units
  localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
  localparam int QUARTER   = 90 << ANGLE_FRAC_BITS;
  localparam int EIGHTH    = 45 << ANGLE_FRAC_BITS;
  localparam int APOS_W    = $clog2(FULL_TURN);
  localparam int R_W       = $clog2(QUARTER);
  localparam int XU_W      = $clog2(EIGHTH + 1);

  // degrees to radians, Q50 scale: (floor(pi * 2^60) >> 10) / 180
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] RAD_Q50 = (PI_Q60 >> 10) / 64'd180;
  localparam int RAD_W    = 45;
  localparam int RAD_LO_W = 22;
  localparam int RAD_HI_W = RAD_W - RAD_LO_W;
  localparam logic [RAD_HI_W-1:0] RAD_HI = RAD_HI_W'(RAD_Q50 >> RAD_LO_W);
  localparam logic [RAD_LO_W-1:0] RAD_LO = RAD_LO_W'(RAD_Q50);
  localparam int RAD_SHIFT = 20 + ANGLE_FRAC_BITS;
  localparam int PP_W      = XU_W + RAD_W + 1;

  // Q30 working format
  localparam int X_W = 30;
  localparam int T_W = 31;
  localparam logic [T_W-1:0] Q30_ONE = T_W'(1) << 30;

  // horner divisors with reciprocals floor(2^31 / d)
  localparam int HORNER_STEPS = 6;
  localparam int DIV_W        = 8;
  localparam int RCP_W        = 31;
  localparam int RCP_SHIFT    = 31;
  localparam logic [DIV_W-1:0] SIN_DIV [HORNER_STEPS] =
    '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [DIV_W-1:0] COS_DIV [HORNER_STEPS] =
    '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [RCP_W-1:0] SIN_RCP [HORNER_STEPS] = '{
    RCP_W'((64'd1 << RCP_SHIFT) / 64'd156), RCP_W'((64'd1 << RCP_SHIFT) / 64'd110),
    RCP_W'((64'd1 << RCP_SHIFT) / 64'd72),  RCP_W'((64'd1 << RCP_SHIFT) / 64'd42),
    RCP_W'((64'd1 << RCP_SHIFT) / 64'd20),  RCP_W'((64'd1 << RCP_SHIFT) / 64'd6)};
  localparam logic [RCP_W-1:0] COS_RCP [HORNER_STEPS] = '{
    RCP_W'((64'd1 << RCP_SHIFT) / 64'd132), RCP_W'((64'd1 << RCP_SHIFT) / 64'd90),
    RCP_W'((64'd1 << RCP_SHIFT) / 64'd56),  RCP_W'((64'd1 << RCP_SHIFT) / 64'd30),
    RCP_W'((64'd1 << RCP_SHIFT) / 64'd12),  RCP_W'((64'd1 << RCP_SHIFT) / 64'd2)};

  // pipeline depth
  localparam int TRIG_STAGES  = 4 + 3 * HORNER_STEPS + 2;
  localparam int BASIS_STAGES = 7;
  localparam int PIPE_DEPTH   = TRIG_STAGES + BASIS_STAGES;

  // signed Q30 sine or cosine, magnitude up to one
  typedef logic signed [31:0] trig_t;

  // quadrant of the reduced angle
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

endpackage

/* src/etcb_trig.sv */
// ----------------------------------------------------------------------------
// etcb_trig
// Pipelined sine and cosine of one angle: octant reduction, radian scaling,
// two six-step horner chains and quadrant reconstruction, Q30 results.
// ----------------------------------------------------------------------------
module etcb_trig (
  input  logic                                 clk,
  input  logic [etcb_pkg::TRIG_STAGES-1:0]     en,
  input  logic signed [etcb_pkg::ANGLE_W-1:0]  angle,
  output etcb_pkg::trig_t                      sin_q,
  output etcb_pkg::trig_t                      cos_q
);
  import etcb_pkg::*;

  localparam int LAST = TRIG_STAGES - 1;

  // stage 0: wrap into one turn, split into quadrant and octant
  logic signed [APOS_W:0] a_s;
  logic signed [APOS_W:0] a_w;
  logic [APOS_W-1:0]      a_pos;
  logic [1:0]             quad;
  logic [APOS_W-1:0]      r_full;
  logic [R_W-1:0]         r;
  logic                   fold;
  logic [XU_W-1:0]        xu;

  always_comb begin
    a_s = (APOS_W + 1)'(angle);
    a_w = a_s[APOS_W] ? a_s + $signed((APOS_W + 1)'(FULL_TURN)) : a_s;
    a_pos = a_w[APOS_W-1:0];
    if (a_pos >= APOS_W'(3 * QUARTER)) begin
      quad   = QUAD_3;
      r_full = a_pos - APOS_W'(3 * QUARTER);
    end else if (a_pos >= APOS_W'(2 * QUARTER)) begin
      quad   = QUAD_2;
      r_full = a_pos - APOS_W'(2 * QUARTER);
    end else if (a_pos >= APOS_W'(QUARTER)) begin
      quad   = QUAD_1;
      r_full = a_pos - APOS_W'(QUARTER);
    end else begin
      quad   = QUAD_0;
      r_full = a_pos;
    end
    r    = r_full[R_W-1:0];
    fold = r > R_W'(EIGHTH);
    xu   = fold ? XU_W'(R_W'(QUARTER) - r) : XU_W'(r);
  end

  logic [XU_W-1:0] xu_r;
  logic [2:0]      qf_r [0:LAST-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xu_r     <= xu;
      qf_r[0]  <= {quad, fold};
    end
  end

  // quadrant and fold ride along to the last stage
  for (genvar s = 1; s < LAST; s++) begin : g_qf
    always_ff @(posedge clk) begin
      if (en[s]) begin
        qf_r[s] <= qf_r[s-1];
      end
    end
  end

  // stage 1: radian scaling as two partial products
  logic [XU_W+RAD_HI_W-1:0] pp_hi_r;
  logic [XU_W+RAD_LO_W-1:0] pp_lo_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pp_hi_r <= (XU_W + RAD_HI_W)'(xu_r) * (XU_W + RAD_HI_W)'(RAD_HI);
      pp_lo_r <= (XU_W + RAD_LO_W)'(xu_r) * (XU_W + RAD_LO_W)'(RAD_LO);
    end
  end

  // stage 2: merge and round to Q30 radians
  logic [PP_W-1:0] x_sum;
  logic [X_W-1:0]  x_r [2:LAST-2];

  assign x_sum = (PP_W'(pp_hi_r) << RAD_LO_W) + PP_W'(pp_lo_r)
               + (PP_W'(1) << (RAD_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x_r[2] <= X_W'(x_sum >> RAD_SHIFT);
    end
  end

  for (genvar s = 3; s <= LAST - 2; s++) begin : g_x
    always_ff @(posedge clk) begin
      if (en[s]) begin
        x_r[s] <= x_r[s-1];
      end
    end
  end

  // stage 3: x squared, rounded
  localparam int X2_LAST = 3 * HORNER_STEPS;
  logic [2*X_W:0] sq;
  logic [X_W-1:0] x2_r [3:X2_LAST];

  assign sq = (2 * X_W + 1)'(x_r[2]) * (2 * X_W + 1)'(x_r[2])
            + ((2 * X_W + 1)'(1) << 29);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x2_r[3] <= X_W'(sq >> 30);
    end
  end

  for (genvar s = 4; s <= X2_LAST; s++) begin : g_x2
    always_ff @(posedge clk) begin
      if (en[s]) begin
        x2_r[s] <= x2_r[s-1];
      end
    end
  end

  // horner steps, lane 0 sine and lane 1 cosine, three stages per step
  logic [X_W-1:0] p_a_r  [2][HORNER_STEPS];
  logic [X_W-1:0] p_b_r  [2][HORNER_STEPS];
  logic [X_W-1:0] qe_b_r [2][HORNER_STEPS];
  logic [T_W-1:0] t_r    [2][HORNER_STEPS];

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
      localparam int SA = 4 + 3 * i;
      localparam logic [DIV_W-1:0] D = (ln == 0) ? SIN_DIV[i] : COS_DIV[i];
      localparam logic [RCP_W-1:0] M = (ln == 0) ? SIN_RCP[i] : COS_RCP[i];

      logic [T_W-1:0]         t_in;
      logic [X_W+T_W-1:0]     prod;
      logic [X_W+RCP_W-1:0]   qprod;
      logic [X_W+DIV_W-1:0]   back;
      logic [X_W+DIV_W-1:0]   rem;
      logic [X_W-1:0]         q;

      if (i == 0) begin : g_first
        assign t_in = Q30_ONE;
      end else begin : g_next
        assign t_in = t_r[ln][i-1];
      end

      // product with x squared
      assign prod = (X_W + T_W)'(x2_r[SA-1]) * (X_W + T_W)'(t_in);

      // quotient estimate by reciprocal
      assign qprod = (X_W + RCP_W)'(p_a_r[ln][i]) * (X_W + RCP_W)'(M);

      // remainder check corrects the estimate by at most one
      assign back = (X_W + DIV_W)'(qe_b_r[ln][i]) * (X_W + DIV_W)'(D);
      assign rem  = (X_W + DIV_W)'(p_b_r[ln][i]) - back;
      assign q    = qe_b_r[ln][i] + X_W'(rem >= (X_W + DIV_W)'(D));

      always_ff @(posedge clk) begin
        if (en[SA]) begin
          p_a_r[ln][i] <= X_W'(prod >> 30);
        end
        if (en[SA+1]) begin
          p_b_r[ln][i]  <= p_a_r[ln][i];
          qe_b_r[ln][i] <= X_W'(qprod >> RCP_SHIFT);
        end
        if (en[SA+2]) begin
          t_r[ln][i] <= Q30_ONE - T_W'(q);
        end
      end
    end
  end

  // stage after horner: sine gets its factor of x
  logic [X_W+T_W-1:0] ps_prod;
  logic [T_W-1:0]     ps_r;
  logic [T_W-1:0]     pc_r;

  assign ps_prod = (X_W + T_W)'(x_r[LAST-2]) * (X_W + T_W)'(t_r[0][HORNER_STEPS-1]);

  always_ff @(posedge clk) begin
    if (en[LAST-1]) begin
      ps_r <= T_W'(ps_prod >> 30);
      pc_r <= t_r[1][HORNER_STEPS-1];
    end
  end

  // last stage: undo the fold, then place in the quadrant
  trig_t ss;
  trig_t cc;
  trig_t sin_nxt;
  trig_t cos_nxt;
  quad_t q_last;
  trig_t sin_r;
  trig_t cos_r;

  always_comb begin
    q_last = quad_t'(qf_r[LAST-1][2:1]);
    if (qf_r[LAST-1][0]) begin
      ss = trig_t'(pc_r);
      cc = trig_t'(ps_r);
    end else begin
      ss = trig_t'(ps_r);
      cc = trig_t'(pc_r);
    end
    case (q_last)
      QUAD_0: begin
        sin_nxt = ss;
        cos_nxt = cc;
      end
      QUAD_1: begin
        sin_nxt = cc;
        cos_nxt = -ss;
      end
      QUAD_2: begin
        sin_nxt = -ss;
        cos_nxt = -cc;
      end
      default: begin
        sin_nxt = -cc;
        cos_nxt = ss;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

/* src/etcb_basis.sv */
// ----------------------------------------------------------------------------
// etcb_basis
// Forward, up and right vectors from Q30 sines and cosines, rounded and
// saturated to the output format.
// ----------------------------------------------------------------------------
module etcb_basis (
  input  logic                                  clk,
  input  logic [etcb_pkg::BASIS_STAGES-1:0]     en,
  input  etcb_pkg::trig_t                       sp,
  input  etcb_pkg::trig_t                       cp,
  input  etcb_pkg::trig_t                       sy,
  input  etcb_pkg::trig_t                       cy,
  input  etcb_pkg::trig_t                       sr,
  input  etcb_pkg::trig_t                       cr,
  output logic signed [etcb_pkg::OUT_W-1:0]     forward_x,
  output logic signed [etcb_pkg::OUT_W-1:0]     forward_y,
  output logic signed [etcb_pkg::OUT_W-1:0]     forward_z,
  output logic signed [etcb_pkg::OUT_W-1:0]     up_x,
  output logic signed [etcb_pkg::OUT_W-1:0]     up_y,
  output logic signed [etcb_pkg::OUT_W-1:0]     up_z,
  output logic signed [etcb_pkg::OUT_W-1:0]     right_x,
  output logic signed [etcb_pkg::OUT_W-1:0]     right_y,
  output logic signed [etcb_pkg::OUT_W-1:0]     right_z
);
  import etcb_pkg::*;

  typedef logic signed [32:0] val_t;
  typedef logic signed [34:0] wide_t;
  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
  } prod_t;

  localparam int OSH = 30 - VECTOR_FRAC_BITS;

  // sign-magnitude product, magnitude not yet rounded
  function automatic prod_t mul_raw(input val_t a, input val_t b);
    logic [31:0] ma;
    logic [31:0] mb;
    prod_t       p;
    ma = a[32] ? 32'(-a) : 32'(a);
    mb = b[32] ? 32'(-b) : 32'(b);
    p.mag = 64'(ma) * 64'(mb);
    p.neg = a[32] ^ b[32];
    return p;
  endfunction

  // round half up in magnitude back to Q30, then apply sign
  function automatic val_t rnd(input prod_t p);
    logic [63:0] s;
    logic [31:0] m;
    s = p.mag + (64'd1 << 29);
    m = 32'(s >> 30);
    return p.neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // round half away from zero to the output format and saturate
  function automatic logic signed [OUT_W-1:0] to_out(input wide_t v);
    logic [34:0] m;
    logic [34:0] r;
    logic [OUT_W-1:0] c;
    m = v[34] ? 35'(-v) : 35'(v);
    r = (m + (35'd1 << (OSH - 1))) >> OSH;
    c = (r > 35'(1 << VECTOR_FRAC_BITS)) ? OUT_W'(1 << VECTOR_FRAC_BITS) : OUT_W'(r);
    return v[34] ? -$signed(c) : $signed(c);
  endfunction

  // stage 0: first level products
  prod_t fx_p_r, fz_p_r, uy_p_r, m1_p_r, m2_p_r, m3_p_r, m4_p_r;
  val_t  sp0_r, cy0_r, cr0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      fx_p_r <= mul_raw(val_t'(sy), val_t'(cp));
      fz_p_r <= mul_raw(val_t'(cp), val_t'(cy));
      uy_p_r <= mul_raw(val_t'(cp), val_t'(cr));
      m1_p_r <= mul_raw(val_t'(cy), val_t'(sr));
      m2_p_r <= mul_raw(val_t'(sy), val_t'(sp));
      m3_p_r <= mul_raw(val_t'(sy), val_t'(sr));
      m4_p_r <= mul_raw(val_t'(sp), val_t'(cr));
      sp0_r  <= val_t'(sp);
      cy0_r  <= val_t'(cy);
      cr0_r  <= val_t'(cr);
    end
  end

  // stage 1: round first level
  val_t fx1_r, fy1_r, fz1_r, uy1_r, m1_r, m2_r, m3_r, m4_r, cy1_r, cr1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fx1_r <= rnd(fx_p_r);
      fy1_r <= sp0_r;
      fz1_r <= -rnd(fz_p_r);
      uy1_r <= rnd(uy_p_r);
      m1_r  <= rnd(m1_p_r);
      m2_r  <= rnd(m2_p_r);
      m3_r  <= rnd(m3_p_r);
      m4_r  <= rnd(m4_p_r);
      cy1_r <= cy0_r;
      cr1_r <= cr0_r;
    end
  end

  // stage 2: second level products
  prod_t m5_p_r, m6_p_r;
  val_t  fx2_r, fy2_r, fz2_r, uy2_r, m1b_r, m3b_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m5_p_r <= mul_raw(m2_r, cr1_r);
      m6_p_r <= mul_raw(m4_r, cy1_r);
      fx2_r  <= fx1_r;
      fy2_r  <= fy1_r;
      fz2_r  <= fz1_r;
      uy2_r  <= uy1_r;
      m1b_r  <= m1_r;
      m3b_r  <= m3_r;
    end
  end

  // stage 3: round and finish the up vector
  val_t fx3_r, fy3_r, fz3_r, ux3_r, uy3_r, uz3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      fx3_r <= fx2_r;
      fy3_r <= fy2_r;
      fz3_r <= fz2_r;
      uy3_r <= uy2_r;
      ux3_r <= -m1b_r - rnd(m5_p_r);
      uz3_r <= -m3b_r + rnd(m6_p_r);
    end
  end

  // stage 4: cross product terms
  prod_t c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  val_t  fx4_r, fy4_r, fz4_r, ux4_r, uy4_r, uz4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      c1_r  <= mul_raw(fy3_r, uz3_r);
      c2_r  <= mul_raw(fz3_r, uy3_r);
      c3_r  <= mul_raw(fz3_r, ux3_r);
      c4_r  <= mul_raw(fx3_r, uz3_r);
      c5_r  <= mul_raw(fx3_r, uy3_r);
      c6_r  <= mul_raw(fy3_r, ux3_r);
      fx4_r <= fx3_r;
      fy4_r <= fy3_r;
      fz4_r <= fz3_r;
      ux4_r <= ux3_r;
      uy4_r <= uy3_r;
      uz4_r <= uz3_r;
    end
  end

  // stage 5: round and difference into the right vector
  wide_t v_r [9];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      v_r[0] <= wide_t'(fx4_r);
      v_r[1] <= wide_t'(fy4_r);
      v_r[2] <= wide_t'(fz4_r);
      v_r[3] <= wide_t'(ux4_r);
      v_r[4] <= wide_t'(uy4_r);
      v_r[5] <= wide_t'(uz4_r);
      v_r[6] <= wide_t'(rnd(c1_r)) - wide_t'(rnd(c2_r));
      v_r[7] <= wide_t'(rnd(c3_r)) - wide_t'(rnd(c4_r));
      v_r[8] <= wide_t'(rnd(c5_r)) - wide_t'(rnd(c6_r));
    end
  end

  // stage 6: output register
  logic signed [OUT_W-1:0] o_r [9];

  for (genvar k = 0; k < 9; k++) begin : g_out
    always_ff @(posedge clk) begin
      if (en[6]) begin
        o_r[k] <= to_out(v_r[k]);
      end
    end
  end

  assign forward_x = o_r[0];
  assign forward_y = o_r[1];
  assign forward_z = o_r[2];
  assign up_x      = o_r[3];
  assign up_y      = o_r[4];
  assign up_z      = o_r[5];
  assign right_x   = o_r[6];
  assign right_y   = o_r[7];
  assign right_z   = o_r[8];

endmodule

/* src/euler_to_camera_basis_unit.sv */
// ----------------------------------------------------------------------------
// euler_to_camera_basis_unit
// Camera forward, up and right unit vectors from pitch, yaw and roll.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    pitch, yaw, roll angles
//   out_     output     out_valid / out_ready  forward, up, right vectors
//
// One beat enters per cycle, unless the output stalls, through 31 register
// stages: 24 in the sine/cosine pipes (six horner steps of three stages
// each) and 7 in the vector stage.
// Each stage holds a valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up and input keeps flowing while the
// output register holds a beat, until no bubble is left. Reset clears the
// valid bits only.
// ----------------------------------------------------------------------------
module euler_to_camera_basis_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [etcb_pkg::ANGLE_W-1:0]  in_pitch_angle,
  input  logic signed [etcb_pkg::ANGLE_W-1:0]  in_yaw_angle,
  input  logic signed [etcb_pkg::ANGLE_W-1:0]  in_roll_angle,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [etcb_pkg::OUT_W-1:0]    out_forward_x,
  output logic signed [etcb_pkg::OUT_W-1:0]    out_forward_y,
  output logic signed [etcb_pkg::OUT_W-1:0]    out_forward_z,
  output logic signed [etcb_pkg::OUT_W-1:0]    out_up_x,
  output logic signed [etcb_pkg::OUT_W-1:0]    out_up_y,
  output logic signed [etcb_pkg::OUT_W-1:0]    out_up_z,
  output logic signed [etcb_pkg::OUT_W-1:0]    out_right_x,
  output logic signed [etcb_pkg::OUT_W-1:0]    out_right_y,
  output logic signed [etcb_pkg::OUT_W-1:0]    out_right_z
);
  import etcb_pkg::*;

  logic [PIPE_DEPTH-1:0] v_r;
  logic [PIPE_DEPTH-1:0] en;

  // stage enables: a stage loads when empty or when its successor loads
  assign en[PIPE_DEPTH-1] = !v_r[PIPE_DEPTH-1] || out_ready;
  for (genvar k = 0; k < PIPE_DEPTH - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[PIPE_DEPTH-1];

  // sine and cosine of each angle
  trig_t sp, cp, sy, cy, sr, cr;

  etcb_trig u_trig_pitch (
    .clk   (clk),
    .en    (en[TRIG_STAGES-1:0]),
    .angle (in_pitch_angle),
    .sin_q (sp),
    .cos_q (cp)
  );

  etcb_trig u_trig_yaw (
    .clk   (clk),
    .en    (en[TRIG_STAGES-1:0]),
    .angle (in_yaw_angle),
    .sin_q (sy),
    .cos_q (cy)
  );

  etcb_trig u_trig_roll (
    .clk   (clk),
    .en    (en[TRIG_STAGES-1:0]),
    .angle (in_roll_angle),
    .sin_q (sr),
    .cos_q (cr)
  );

  // basis vectors and output register
  etcb_basis u_basis (
    .clk       (clk),
    .en        (en[PIPE_DEPTH-1:TRIG_STAGES]),
    .sp        (sp),
    .cp        (cp),
    .sy        (sy),
    .cy        (cy),
    .sr        (sr),
    .cr        (cr),
    .forward_x (out_forward_x),
    .forward_y (out_forward_y),
    .forward_z (out_forward_z),
    .up_x      (out_up_x),
    .up_y      (out_up_y),
    .up_z      (out_up_z),
    .right_x   (out_right_x),
    .right_y   (out_right_y),
    .right_z   (out_right_z)
  );

endmodule
